// ----- rtl/oick_pkg.sv -----
// ----------------------------------------------------------------------------
// oick_pkg: shared constants and helpers for omni chassis inverse kinematics
// Sine approximation coefficients, kinematic constants, register indexes and
// saturation helpers.
// ----------------------------------------------------------------------------
package oick_pkg;

  // Sine polynomial coefficients, Q14
  localparam logic [14:0] SIN_A   = 15'd25736;
  localparam logic [13:0] SIN_B   = 14'd10512;
  localparam logic [10:0] SIN_C   = 11'd1160;
  localparam logic [14:0] SIN_ONE = 15'd16384;

  // sqrt2/2 and sqrt2, Q1.16
  localparam logic signed [51:0] HALF_SQRT2_Q16 = 52'sd46341;
  localparam logic signed [51:0] SQRT2_Q16      = 52'sd92682;

  // Configuration register indexes
  localparam logic CFG_WHEEL_RADIUS = 1'b0;
  localparam logic CFG_INV_RADIUS   = 1'b1;

  typedef logic signed [15:0] sin_q14_t;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] x);
    if (x > 32'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (x < -32'sd8388608) begin
      return 24'sh800000;
    end
    return x[23:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [23:0] x);
    if (x > 24'sd32767) begin
      return 16'sh7FFF;
    end else if (x < -24'sd32768) begin
      return 16'sh8000;
    end
    return x[15:0];
  endfunction

endpackage

// ----- rtl/oick_sine.sv -----
// ----------------------------------------------------------------------------
// oick_sine: four-stage pipelined sine generator
// Quarter-wave polynomial, one multiply per stage, Q1.14 signed result.
// ----------------------------------------------------------------------------
module oick_sine (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [15:0]         phase_i,
  output oick_pkg::sin_q14_t  sin_o
);
  import oick_pkg::*;

  logic [14:0] ue;
  logic [14:0] u1_q, u2_q, u3_q;
  logic        n1_q, n2_q, n3_q;
  logic [14:0] sq1_q, sq2_q;
  logic [13:0] t1_q;
  logic [14:0] t2_q;
  logic [29:0] sq_full, mag_full;
  logic [25:0] c_full;
  logic [28:0] p_full;
  logic [14:0] mag;
  sin_q14_t    sin_q;

  // odd quadrants mirror the fraction
  assign ue       = phase_i[14] ? (SIN_ONE - {1'b0, phase_i[13:0]}) : {1'b0, phase_i[13:0]};
  assign sq_full  = 30'(ue) * 30'(ue);
  assign c_full   = 26'(SIN_C) * 26'(sq1_q);
  assign p_full   = 29'(sq2_q) * 29'(t1_q);
  assign mag_full = 30'(u3_q) * 30'(t2_q);
  assign mag      = (mag_full[28:14] > SIN_ONE) ? SIN_ONE : mag_full[28:14];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u1_q  <= ue;
      n1_q  <= phase_i[15];
      sq1_q <= sq_full[28:14];
      u2_q  <= u1_q;
      n2_q  <= n1_q;
      sq2_q <= sq1_q;
      t1_q  <= SIN_B - 14'(c_full[25:14]);
      u3_q  <= u2_q;
      n3_q  <= n2_q;
      t2_q  <= SIN_A - 15'(p_full[28:14]);
      sin_q <= n3_q ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end
  end

  assign sin_o = sin_q;

endmodule

// ----- rtl/omni_chassis_inverse_kinematics.sv -----
// ----------------------------------------------------------------------------
// omni_chassis_inverse_kinematics: X-configuration four-wheel omni IK
// Yaw rotation of velocity and force, wheel kinematics, speed and torque
// scaling with saturation.
// ----------------------------------------------------------------------------
// Seven-stage pipeline, one transfer per cycle unless the output stalls.
// Stages 1-4 generate sin/cos of yaw (one polynomial multiply each), stage
// 5 rotates the planar pairs, stage 6 forms the wheel combinations scaled
// by sqrt2/2 (velocity) and sqrt2 (force), stage 7 scales by the radius
// registers, rounds and saturates. The whole pipe advances whenever the
// output register is empty or being taken, so s_axis_tready follows
// m_axis_tready when full. Radius registers should only be written while
// the pipe is empty; they feed stage 7 directly.
module omni_chassis_inverse_kinematics (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [15:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // yaw, vel_x, vel_y, vel_spin, force_x, force_y, force_spin (16 bits each)
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // wheel_speed_1..4 (24 bits each), wheel_torque_1..4 (16 bits each)
  output logic [159:0] m_axis_tdata
);
  import oick_pkg::*;

  logic [15:0] radius_q, inv_radius_q;
  logic [6:0]  v_q;
  logic        adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q     <= 16'd4981;
      inv_radius_q <= 16'd3369;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_WHEEL_RADIUS: radius_q     <= cfg_wdata_i;
        CFG_INV_RADIUS:   inv_radius_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stall the whole pipe only when the output holds an untaken result
  assign adv           = !v_q[6] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = v_q[6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[5:0], s_axis_tvalid};
    end
  end

  // stages 1-4: sin and cos
  sin_q14_t    s_w, c_w;
  logic [15:0] cos_phase;
  assign cos_phase = s_axis_tdata[15:0] + 16'd16384;

  oick_sine u_sin (.clk_i(clk_i), .en_i(adv), .phase_i(s_axis_tdata[15:0]), .sin_o(s_w));
  oick_sine u_cos (.clk_i(clk_i), .en_i(adv), .phase_i(cos_phase),          .sin_o(c_w));

  // velocity/force delay line matching the sine latency
  logic [95:0] dl_q [4];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      dl_q[0] <= s_axis_tdata[111:16];
      dl_q[1] <= dl_q[0];
      dl_q[2] <= dl_q[1];
      dl_q[3] <= dl_q[2];
    end
  end

  logic signed [15:0] vx, vy, vz, fx, fy, fz;
  assign vx = dl_q[3][15:0];
  assign vy = dl_q[3][31:16];
  assign vz = dl_q[3][47:32];
  assign fx = dl_q[3][63:48];
  assign fy = dl_q[3][79:64];
  assign fz = dl_q[3][95:80];

  // stage 5: counter-clockwise rotation (velocity Q26, force Q18)
  logic signed [31:0] rvx_q, rvy_q, rfx_q, rfy_q;
  logic signed [15:0] vz5_q, fz5_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rvx_q <= 32'(vx) * 32'(c_w) - 32'(vy) * 32'(s_w);
      rvy_q <= 32'(vx) * 32'(s_w) + 32'(vy) * 32'(c_w);
      rfx_q <= 32'(fx) * 32'(c_w) - 32'(fy) * 32'(s_w);
      rfy_q <= 32'(fx) * 32'(s_w) + 32'(fy) * 32'(c_w);
      vz5_q <= vz;
      fz5_q <= fz;
    end
  end

  // stage 6: wheel combinations, rounded to Q16 (velocity) and Q14 (force)
  logic signed [32:0] dv [4];
  logic signed [32:0] df [4];
  logic signed [51:0] vacc [4];
  logic signed [51:0] facc [4];
  logic signed [25:0] v16_q [4];
  logic signed [29:0] f16_q [4];

  always_comb begin
    dv[0] = -33'(rvx_q) + 33'(rvy_q);
    dv[1] = -33'(rvx_q) - 33'(rvy_q);
    dv[2] =  33'(rvx_q) - 33'(rvy_q);
    dv[3] =  33'(rvx_q) + 33'(rvy_q);
    df[0] = -33'(rfx_q) + 33'(rfy_q);
    df[1] = -33'(rfx_q) - 33'(rfy_q);
    df[2] =  33'(rfx_q) - 33'(rfy_q);
    df[3] =  33'(rfx_q) + 33'(rfy_q);
    for (int i = 0; i < 4; i++) begin
      vacc[i] = (52'(dv[i]) * HALF_SQRT2_Q16 + (52'(vz5_q) <<< 30)
                 + 52'sd33554432) >>> 26;
      facc[i] = (52'(df[i]) * SQRT2_Q16 + (52'(fz5_q) <<< 30)
                 + 52'sd524288) >>> 20;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        v16_q[i] <= vacc[i][25:0];
        f16_q[i] <= facc[i][29:0];
      end
    end
  end

  // stage 7: radius scaling, round, saturate
  logic signed [43:0] wprod [4];
  logic signed [47:0] tprod [4];
  logic [159:0]       out_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      wprod[i] = (44'(v16_q[i]) * $signed({28'd0, inv_radius_q}) + 44'sd2048) >>> 12;
      tprod[i] = (48'(f16_q[i]) * $signed({32'd0, radius_q}) + 48'sd8388608) >>> 24;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        out_q[24*i +: 24]      <= sat24(wprod[i][31:0]);
        out_q[96 + 16*i +: 16] <= sat16(tprod[i][23:0]);
      end
    end
  end

  assign m_axis_tdata = out_q;

`ifndef SYNTHESIS
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> v_q[0])
    else $error("accepted transfer did not enter the pipe");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(v_q))
    else $error("pipe moved during a stall");

  a_drain : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !v_q[5] |=> !m_axis_tvalid)
    else $error("output repeated after transfer");
`endif

endmodule
